/* rtl/septet_packer_top_macros.svh */
// Assertion macros shared by the septet packer RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef SEPTET_PACKER_TOP_MACROS_SVH
`define SEPTET_PACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Whenever ante holds, cons must hold in the same cycle
`define SP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("septet packer check failed");
// Whenever ante holds, cons must hold in the next cycle
`define SP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("septet packer check failed");
`else
`define SP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/sp_pkg.sv */
// Package for the septet packer: sizing constants and the job types passed
// between the front end, the job queue and the byte emitter. No dependencies.
package sp_pkg;

  // Character and byte sizing
  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int SYMBOL_BITS = 7;  // 5..7
  localparam int GROUP_CHARS = 8;
  localparam int GROUP_BITS  = SYMBOL_BITS * GROUP_CHARS;

  // Derived widths
  localparam int HELD_W  = $clog2(GROUP_CHARS);
  localparam int SHIFT_W = $clog2(GROUP_BITS);
  localparam int BITS_W  = $clog2(GROUP_BITS + BYTE_W);
  localparam int CNT_W   = $clog2(SYMBOL_BITS + 1);

  // Job queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One flush job: packed bits, low byte first, and how many bytes to send
  typedef struct packed {
    logic [GROUP_BITS-1:0] bits;
    logic [CNT_W-1:0]      nbytes;
  } job_t;

  // Front end to queue
  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/sp_front.sv */
// Front end of the septet packer: takes characters, packs them into the
// group buffer and issues a flush job on a full group or message end. Uses sp_pkg.
`include "septet_packer_top_macros.svh"

module sp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sp_pkg::CHAR_W-1:0] char_i,
  input  logic                      last_i,
  input  sp_pkg::q_status_t         q_status_i,
  output sp_pkg::job_req_t          job_req_o
);
  import sp_pkg::*;

  logic [GROUP_BITS-1:0] buf_q, buf_d;
  logic [HELD_W-1:0]     held_q, held_d;
  logic [GROUP_BITS-1:0] sym_ext;
  logic [SHIFT_W-1:0]    shift;
  logic [GROUP_BITS-1:0] merged;
  logic [HELD_W:0]       held_inc;
  logic [BITS_W-1:0]     bits_rnd;
  logic                  accept;
  logic                  emit;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Merge the new character in at its slot and size the flush
  always_comb begin
    sym_ext  = GROUP_BITS'(char_i[SYMBOL_BITS-1:0]);
    shift    = SHIFT_W'(held_q) * SHIFT_W'(SYMBOL_BITS);
    merged   = buf_q | (sym_ext << shift);
    held_inc = {1'b0, held_q} + (HELD_W+1)'(1);
    bits_rnd = BITS_W'(held_inc) * BITS_W'(SYMBOL_BITS) + BITS_W'(BYTE_W - 1);
    emit     = (held_q == HELD_W'(GROUP_CHARS - 1)) || last_i;
  end

  assign job_req_o.push       = accept && emit;
  assign job_req_o.job.bits   = merged;
  assign job_req_o.job.nbytes = CNT_W'(bits_rnd >> 3);

  // Buffer and count update
  always_comb begin
    buf_d  = buf_q;
    held_d = held_q;
    if (accept) begin
      if (emit) begin
        buf_d  = '0;
        held_d = '0;
      end else begin
        buf_d  = merged;
        held_d = held_inc[HELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
    end
  end

  // A message end always leaves the buffer empty
  `SP_ASSERT_NEXT(end_clears_a, clk_i, rst_ni, accept && last_i, held_q == '0 && buf_q == '0)

endmodule

/* rtl/sp_queue.sv */
// Short job queue between the packer front end and the byte emitter.
// Register-based ring of sp_pkg::job_t entries; uses sp_pkg.
`include "septet_packer_top_macros.svh"

module sp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sp_pkg::job_req_t  job_req_i,
  input  logic              pop_i,
  output sp_pkg::job_t      head_o,
  output sp_pkg::q_status_t status_o
);
  import sp_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else                               r = p + QPTR_W'(1);
    return r;
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = slot_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = job_req_i.push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (job_req_i.push && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (!job_req_i.push && pop_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, payload only
  always_ff @(posedge clk_i) begin
    if (job_req_i.push) slot_q[wr_ptr_q] <= job_req_i.job;
  end

  `SP_ASSERT_IMPLIES(no_overflow_a, clk_i, rst_ni, job_req_i.push, !status_o.full)
  `SP_ASSERT_IMPLIES(no_underflow_a, clk_i, rst_ni, pop_i, !status_o.empty)

endmodule

/* rtl/sp_back.sv */
// Byte emitter of the septet packer: takes flush jobs from the queue and
// sends their bytes one beat at a time from an output register. Uses sp_pkg.
`include "septet_packer_top_macros.svh"

module sp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sp_pkg::q_status_t         q_status_i,
  input  sp_pkg::job_t              head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sp_pkg::BYTE_W-1:0] byte_o,
  output logic                      last_o
);
  import sp_pkg::*;

  logic [GROUP_BITS-1:0] data_q, data_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic                  valid_q, valid_d;
  logic                  beat;
  logic                  final_beat;

  assign beat        = valid_q && out_ready_i;
  assign final_beat  = (rem_q == CNT_W'(1));
  assign pop_o       = !q_status_i.empty && (!valid_q || (beat && final_beat));
  assign out_valid_o = valid_q;
  assign byte_o      = data_q[BYTE_W-1:0];
  assign last_o      = final_beat;

  // Shift out one byte per beat; reload from the queue on the last one
  always_comb begin
    data_d  = data_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    if (beat) begin
      data_d = data_q >> BYTE_W;
      rem_d  = rem_q - CNT_W'(1);
      if (final_beat) valid_d = 1'b0;
    end
    if (pop_o) begin
      data_d  = head_i.bits;
      rem_d   = head_i.nbytes;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // A held byte always has a live count behind it
  `SP_ASSERT_IMPLIES(rem_live_a, clk_i, rst_ni, valid_q, rem_q != '0)

endmodule

/* rtl/septet_packer_top.sv */
// Top level of the septet packer: front end, job queue and byte emitter.
// Depends on sp_pkg, sp_front, sp_queue and sp_back.
//
//   channel   dir   tdata                        tlast
//   s_axis    in    [6:0] char_in, [7] zero      message_end
//   m_axis    out   [7:0] packed_byte            run_last
//
// One character accepted per cycle while the job queue has room; characters
// completing a group of eight or ending a message push one job of up to
// seven bytes.
// Bytes leave at one per cycle from the emitter's output register while m_axis_tready
// is high; on full groups 7 beats leave per 8 characters.
// The causing character's job passes a queue slot, then the emitter's output register.
// Reset clears the buffer and empties the queue and emitter; no clearing pass is needed.
// Either side may stall freely; the two-entry queue decouples them.

module septet_packer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [6:0] char_in, [7] pad
  input  logic       s_axis_tlast,   // message_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] packed_byte
  output logic       m_axis_tlast    // run_last
);
  import sp_pkg::*;

  job_req_t  job_req;
  q_status_t q_status;
  job_t      head;
  logic      pop;

  sp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata[CHAR_W-1:0]),
    .last_i     (s_axis_tlast),
    .q_status_i (q_status),
    .job_req_o  (job_req)
  );

  sp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_req_i (job_req),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (q_status)
  );

  sp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .byte_o      (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule
